// ----- hdl/fwq_pkg.sv -----
// Shared types and constants for the futex wait queue.
// Holds the request/result structs, slot format, chain controls and code values.
// Used by fwq_cell, fwq_ctrl and futex_wait_queue.
package fwq_pkg;

    localparam int WAITERS = 16;
    localparam int ID_BITS = 8;
    localparam int IDX_W   = $clog2(WAITERS);
    localparam int CNT_W   = $clog2(WAITERS + 1);

    localparam logic [1:0] OP_WAIT    = 2'd0;
    localparam logic [1:0] OP_WAKE    = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;
    localparam logic [1:0] OP_UNSUP   = 2'd3;

    localparam logic [2:0] K_MISMATCH = 3'd0;
    localparam logic [2:0] K_QUEUED   = 3'd1;
    localparam logic [2:0] K_FULL     = 3'd2;
    localparam logic [2:0] K_WOKEN    = 3'd3;
    localparam logic [2:0] K_DONE     = 3'd4;
    localparam logic [2:0] K_TIMEDOUT = 3'd5;
    localparam logic [2:0] K_NOTWAIT  = 3'd6;
    localparam logic [2:0] K_UNSUP    = 3'd7;

    typedef struct packed {
        logic [1:0]          op;
        logic [31:0]         addr;
        logic signed [31:0]  value;
        logic signed [31:0]  current;
        logic [7:0]          waiter;
    } req_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] waiter_res;
        logic [4:0] woken_total;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic               valid;
        logic [31:0]        addr;
        logic [ID_BITS-1:0] id;
    } slot_t;

    // Controls broadcast from the sequencer to the whole chain.
    typedef struct packed {
        logic             shift;
        logic             load;
        logic [IDX_W-1:0] load_idx;
        slot_t            load_data;
    } chain_ctl_t;

    // Per-cell decoded controls.
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN
    } state_t;

endpackage

// ----- hdl/fwq_cell.sv -----
// One slot of the waiter chain: holds an address, a waiter id and a valid bit.
// Loads a new entry, takes its upper neighbor on a shift, or holds.
// Depends on fwq_pkg.
module fwq_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  fwq_pkg::cell_ctl_t ctl,
    input  fwq_pkg::slot_t    load_data,
    input  fwq_pkg::slot_t    nbr,
    output fwq_pkg::slot_t    slot
);
    import fwq_pkg::*;

    logic               valid_reg;
    logic [31:0]        addr_reg;
    logic [ID_BITS-1:0] id_reg;
    slot_t              slot_cur;
    slot_t              slot_next;

    assign slot_cur = '{valid: valid_reg, addr: addr_reg, id: id_reg};

    always_comb
    begin
        if (ctl.load)
        begin
            slot_next = load_data;
        end
        else if (ctl.shift)
        begin
            slot_next = nbr;
        end
        else
        begin
            slot_next = slot_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= slot_next.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        addr_reg <= slot_next.addr;
        id_reg   <= slot_next.id;
    end

    assign slot = slot_cur;

endmodule

// ----- hdl/fwq_ctrl.sv -----
// Sequencer of the futex wait queue: takes requests, drives the slot chain,
// rotates the chain for wake and timeout scans, and owns the result register.
// Depends on fwq_pkg.
module fwq_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  fwq_pkg::req_t        req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output fwq_pkg::rsp_t        rsp,
    input  fwq_pkg::slot_t       head,
    output fwq_pkg::chain_ctl_t  chain
);
    import fwq_pkg::*;

    state_t             state_reg, state_next;
    req_t               req_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   steps_reg, steps_next;
    logic [CNT_W-1:0]   woken_reg, woken_next;
    logic               found_reg, found_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    logic               out_free;
    logic [ID_BITS-1:0] who;
    logic               wake_ok;
    logic               take;
    logic               step;
    logic               finish;

    assign out_free = !out_valid_reg || !rsp_stall;
    assign who      = ID_BITS'(req_reg.waiter);
    // wake limit counts only when positive
    assign wake_ok  = !req_reg.value[31]
                      && (32'(woken_reg) < $unsigned(req_reg.value));
    assign take     = (req_reg.op == OP_WAKE)
                      ? (head.addr == req_reg.addr) && wake_ok
                      : (head.id == who) && !found_reg;
    assign step     = (state_reg == ST_SCAN) && (steps_reg != '0) && out_free;
    assign finish   = (state_reg == ST_SCAN) && (steps_reg == '0) && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    if (req_reg.op == OP_WAKE || req_reg.op == OP_TIMEOUT)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        count_next      = count_reg;
        steps_next      = steps_reg;
        woken_next      = woken_reg;
        found_next      = found_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && rsp_stall;
        chain.shift     = 1'b0;
        chain.load      = 1'b0;
        chain.load_idx  = IDX_W'(count_reg);
        chain.load_data = '{valid: 1'b1, addr: req_reg.addr, id: who};

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_DECIDE:
            begin
                if (out_free)
                begin
                    steps_next = count_reg;
                    woken_next = '0;
                    found_next = 1'b0;
                    unique case (req_reg.op) inside
                        OP_WAIT:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '{kind: K_MISMATCH, waiter_res: 8'd0,
                                               woken_total: 5'd0, last: 1'b1};
                            if (req_reg.current == req_reg.value)
                            begin
                                if (count_reg >= CNT_W'(WAITERS))
                                begin
                                    out_next.kind = K_FULL;
                                end
                                else
                                begin
                                    chain.load          = 1'b1;
                                    count_next          = count_reg + CNT_W'(1);
                                    out_next.kind       = K_QUEUED;
                                    out_next.waiter_res = 8'(who);
                                end
                            end
                        end
                        OP_WAKE, OP_TIMEOUT:
                        begin
                        end
                        OP_UNSUP:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '{kind: K_UNSUP, waiter_res: 8'd0,
                                               woken_total: 5'd0, last: 1'b1};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (step)
                begin
                    // pop the head; push it back at the tail unless released
                    chain.shift = 1'b1;
                    steps_next  = steps_reg - CNT_W'(1);
                    if (take)
                    begin
                        count_next = count_reg - CNT_W'(1);
                        if (req_reg.op == OP_WAKE)
                        begin
                            woken_next     = woken_reg + CNT_W'(1);
                            out_valid_next = 1'b1;
                            out_next       = '{kind: K_WOKEN, waiter_res: 8'(head.id),
                                               woken_total: 5'd0, last: 1'b0};
                        end
                        else
                        begin
                            found_next = 1'b1;
                        end
                    end
                    else
                    begin
                        chain.load      = 1'b1;
                        chain.load_idx  = IDX_W'(count_reg - CNT_W'(1));
                        chain.load_data = head;
                    end
                end
                else if (finish)
                begin
                    out_valid_next = 1'b1;
                    if (req_reg.op == OP_WAKE)
                    begin
                        out_next = '{kind: K_DONE, waiter_res: 8'd0,
                                     woken_total: 5'(woken_reg), last: 1'b1};
                    end
                    else if (found_reg)
                    begin
                        out_next = '{kind: K_TIMEDOUT, waiter_res: 8'(who),
                                     woken_total: 5'd0, last: 1'b1};
                    end
                    else
                    begin
                        out_next = '{kind: K_NOTWAIT, waiter_res: 8'd0,
                                     woken_total: 5'd0, last: 1'b1};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            steps_reg     <= '0;
            woken_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            steps_reg     <= steps_next;
            woken_reg     <= woken_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid)
        begin
            req_reg <= req;
        end
        out_reg <= out_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(WAITERS))
        else $error("queued count exceeds table size");

    a_steps_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= count_reg)
        else $error("scan step count exceeds queued count");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && steps_reg != '0) |-> head.valid)
        else $error("scan reached an empty head slot");

    a_woken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (step && take && req_reg.op == OP_WAKE) |=> woken_reg == $past(woken_reg) + CNT_W'(1))
        else $error("woken total not advanced on release");

endmodule

// ----- hdl/futex_wait_queue.sv -----
// Top level of the futex wait queue: sequencer plus a chain of WAITERS slot cells.
// Depends on fwq_pkg, fwq_cell and fwq_ctrl.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one request: wait, wake,
//   timeout or an unsupported op. rsp channel (rsp_valid / rsp_stall / rsp)
//   returns results; the final result of a request has last set.
//   Requests are handled one at a time. A wait or unsupported op gives its
//   single result from the decide state, once the output register is free.
//   Wake and timeout rotate the whole chain once, one slot per cycle through
//   the head cell while the output is not stalled; a wake emits each released
//   waiter as the head passes, then the done total.
//   The next request is taken the cycle after the final result is loaded into
//   the output register, while that result may still wait on rsp_stall.
//   When the receiver stalls, hold the output register and freeze the scan.
//   Reset clears the slot valid bits, the count and all control state; slot
//   addresses and ids are garbage until written. No clearing pass is needed.
module futex_wait_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  fwq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output fwq_pkg::rsp_t  rsp
);
    import fwq_pkg::*;

    chain_ctl_t chain;
    slot_t      slots [WAITERS];

    fwq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .head      (slots[0]),
        .chain     (chain)
    );

    // Cells shift toward slot 0; the head cell feeds the sequencer and the
    // tail slot takes either a new waiter or a recycled head entry.
    for (genvar i = 0; i < WAITERS; i++)
    begin : g_cell
        cell_ctl_t ctl;
        slot_t     nbr;

        assign ctl.shift = chain.shift;
        assign ctl.load  = chain.load && (chain.load_idx == IDX_W'(i));

        if (i == WAITERS - 1)
        begin : g_top
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = slots[i + 1];
        end

        fwq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .load_data (chain.load_data),
            .nbr       (nbr),
            .slot      (slots[i])
        );
    end

endmodule

// ----- bench/futex_wait_queue_test.sv -----
`timescale 1ns / 100ps
// Testbench for futex_wait_queue: directed table, then random wait/wake/timeout/unsupported traffic.
// Holds its own model of the waiter table; depends only on fwq_pkg and the block.
module futex_wait_queue_test;
    import fwq_pkg::*;

    // One row of the directed plan. When typed is set, want is the single
    // result of the request, written out by hand. Otherwise the table model
    // supplies the results.
    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } plan_row_t;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Model of the waiter table, oldest first. Removal closes the gap.
    logic [31:0]        wait_addr[$];
    logic [ID_BITS-1:0] wait_id[$];

    rsp_t      table_results[$];    // results of the request just modeled
    rsp_t      pending_results[$];  // results still owed by the block, oldest first
    plan_row_t plan[$];

    logic [31:0] addr_pool[4];
    logic [7:0]  id_pool[6];

    int send_idle_pct  = 38;
    int recv_stall_pct = 80;
    int mismatch_count = 0;

    futex_wait_queue u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Kill the run if it is still going when the time limit below runs out.
    initial
    begin
        #4_000_000;
        $display("%0t: timeout, %0d results still owed", $time, pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    function automatic rsp_t result_of(input logic [2:0] kind, input logic [7:0] who,
                                       input logic [4:0] total, input logic last);
        rsp_t x;
        x.kind        = kind;
        x.waiter_res  = who;
        x.woken_total = total;
        x.last        = last;
        return x;
    endfunction

    // Apply one accepted request to the table model and collect its results.
    function automatic void advance_wait_table(input req_t r);
        logic [ID_BITS-1:0] who;
        logic [31:0]        limit;
        logic [31:0]        woken;
        int                 i;
        bit                 found;
        who = r.waiter[ID_BITS-1:0];
        table_results.delete();
        case (r.op)
            OP_WAIT:
            begin
                if (r.current != r.value)
                    table_results.push_back(result_of(K_MISMATCH, 8'd0, 5'd0, 1'b1));
                else if (wait_addr.size() >= WAITERS)
                    table_results.push_back(result_of(K_FULL, 8'd0, 5'd0, 1'b1));
                else
                begin
                    wait_addr.push_back(r.addr);
                    wait_id.push_back(who);
                    table_results.push_back(result_of(K_QUEUED, 8'(who), 5'd0, 1'b1));
                end
            end
            OP_WAKE:
            begin
                // A negative limit wakes nobody, same as zero.
                limit = r.value[31] ? 32'd0 : r.value;
                woken = 32'd0;
                i = 0;
                while (i < wait_addr.size() && woken < limit)
                begin
                    if (wait_addr[i] == r.addr)
                    begin
                        table_results.push_back(result_of(K_WOKEN, 8'(wait_id[i]), 5'd0, 1'b0));
                        wait_addr.delete(i);
                        wait_id.delete(i);
                        woken++;
                    end
                    else
                        i++;
                end
                table_results.push_back(result_of(K_DONE, 8'd0, 5'(woken), 1'b1));
            end
            OP_TIMEOUT:
            begin
                // Drop the oldest entry with this id, whatever its address.
                found = 1'b0;
                for (i = 0; i < wait_id.size() && !found; i++)
                begin
                    if (wait_id[i] == who)
                    begin
                        wait_addr.delete(i);
                        wait_id.delete(i);
                        found = 1'b1;
                    end
                end
                if (found)
                    table_results.push_back(result_of(K_TIMEDOUT, 8'(who), 5'd0, 1'b1));
                else
                    table_results.push_back(result_of(K_NOTWAIT, 8'd0, 5'd0, 1'b1));
            end
            default:
                table_results.push_back(result_of(K_UNSUP, 8'd0, 5'd0, 1'b1));
        endcase
    endfunction

    function automatic void add_row(input logic [1:0] op, input logic [31:0] addr,
                                    input logic [31:0] value, input logic [31:0] current,
                                    input logic [7:0] waiter, input bit typed,
                                    input rsp_t want);
        plan_row_t row;
        row.r.op      = op;
        row.r.addr    = addr;
        row.r.value   = value;
        row.r.current = current;
        row.r.waiter  = waiter;
        row.typed     = typed;
        row.want      = want;
        plan.push_back(row);
    endfunction

    function automatic void fill_plan();
        int i;
        // Empty table: timeout and wake find nobody.
        add_row(OP_TIMEOUT, 32'h0, 32'h0, 32'h0, 8'h05, 1'b1,
                result_of(K_NOTWAIT, 8'd0, 5'd0, 1'b1));
        add_row(OP_WAKE, 32'h1000, 32'd5, 32'h0, 8'h00, 1'b1,
                result_of(K_DONE, 8'd0, 5'd0, 1'b1));
        add_row(OP_UNSUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1,
                result_of(K_UNSUP, 8'd0, 5'd0, 1'b1));
        // Mismatch with the value extremes, then queue at the address extremes.
        add_row(OP_WAIT, 32'h1000, 32'h7FFF_FFFF, 32'h8000_0000, 8'h01, 1'b1,
                result_of(K_MISMATCH, 8'd0, 5'd0, 1'b1));
        add_row(OP_WAIT, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 8'hFF, 1'b1,
                result_of(K_QUEUED, 8'hFF, 5'd0, 1'b1));
        add_row(OP_WAIT, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'h00, 1'b1,
                result_of(K_QUEUED, 8'h00, 5'd0, 1'b1));
        // Fill the table on two addresses, every id used twice.
        for (i = 0; i < WAITERS - 2; i++)
            add_row(OP_WAIT, (i % 3 == 2) ? 32'h2000 : 32'h1000, 32'(i), 32'(i),
                    8'h10 + 8'(i % 7), 1'b0, '0);
        add_row(OP_WAIT, 32'h3000, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 8'h20, 1'b1,
                result_of(K_FULL, 8'd0, 5'd0, 1'b1));
        // Zero and negative limits wake nobody even with waiters on the address.
        add_row(OP_WAKE, 32'h1000, 32'd0, 32'hFFFF_FFFF, 8'hAA, 1'b1,
                result_of(K_DONE, 8'd0, 5'd0, 1'b1));
        add_row(OP_WAKE, 32'h1000, 32'h8000_0000, 32'h0, 8'h00, 1'b1,
                result_of(K_DONE, 8'd0, 5'd0, 1'b1));
        // Duplicate id: the oldest goes, and addr plays no part.
        add_row(OP_TIMEOUT, 32'hDEAD_BEEF, 32'h0, 32'h0, 8'h10, 1'b0, '0);
        add_row(OP_WAKE, 32'h1000, 32'd3, 32'h0, 8'h00, 1'b0, '0);
        add_row(OP_WAKE, 32'h1000, 32'h7FFF_FFFF, 32'h0, 8'h00, 1'b0, '0);
        add_row(OP_WAKE, 32'hFFFF_FFFF, 32'd1, 32'h0, 8'h00, 1'b0, '0);
    endfunction

    // Random request, biased toward a few shared addresses and ids so that
    // waits pile up, wakes find waiters and timeouts hit queued entries.
    function automatic req_t random_request();
        req_t r;
        int   pick;
        r.op      = OP_WAIT;
        r.addr    = $urandom();
        r.value   = $urandom();
        r.current = $urandom();
        r.waiter  = 8'($urandom());
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            r.op = OP_WAIT;
            if ($urandom_range(0, 9) != 0)
                r.addr = addr_pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 99) < 85)
                r.current = r.value;
            if ($urandom_range(0, 9) < 6)
                r.waiter = id_pool[$urandom_range(0, 5)];
        end
        else if (pick < 75)
        begin
            r.op = OP_WAKE;
            if ($urandom_range(0, 9) != 0)
                r.addr = addr_pool[$urandom_range(0, 3)];
            case ($urandom_range(0, 19))
                0:       r.value = 32'd0;
                1:       r.value = {1'b1, 31'($urandom())};
                2:       r.value = $urandom();
                3:       r.value = 32'h7FFF_FFFF;
                default: r.value = 32'($urandom_range(1, 4));
            endcase
        end
        else if (pick < 93)
        begin
            r.op = OP_TIMEOUT;
            if (wait_id.size() != 0 && $urandom_range(0, 9) < 7)
                r.waiter = 8'(wait_id[$urandom_range(0, wait_id.size() - 1)]);
        end
        else
            r.op = OP_UNSUP;
        return r;
    endfunction

    // Offer one request, idling at random first; hold it until accepted and
    // then record what the block owes for it.
    task automatic send_request(input req_t r, input bit typed, input rsp_t want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        advance_wait_table(r);
        if (typed)
            pending_results.push_back(want);
        else
            foreach (table_results[j])
                pending_results.push_back(table_results[j]);
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int k;
        fill_plan();
        foreach (addr_pool[j])
            addr_pool[j] = $urandom();
        foreach (id_pool[j])
            id_pool[j] = 8'($urandom());
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: sender idles lightly, receiver stalls heavily.
        foreach (plan[j])
            send_request(plan[j].r, plan[j].typed, plan[j].want);
        wait_for_results();

        // Random part in three idling phases; drain at every phase change.
        for (k = 0; k < 85; k++)
        begin
            if (k == 25)
            begin
                wait_for_results();
                send_idle_pct  = 80;
                recv_stall_pct = 38;
            end
            else if (k == 55)
            begin
                wait_for_results();
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            send_request(random_request(), 1'b0, '0);
        end

        // Let the last results out, then give stray ones time to show up.
        wait_for_results();
        repeat (25)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    function automatic void check_field(input string name, input logic [7:0] want_v,
                                        input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
            mismatch_count++;
        end
    endfunction

    // Check each accepted result against the oldest owed one, then pick the
    // stall for the next cycle.
    always @(posedge clk)
    begin : rsp_check
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result kind %0d waiter %0d total %0d with nothing owed",
                         $time, rsp.kind, rsp.waiter_res, rsp.woken_total);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("kind", 8'(want.kind), 8'(rsp.kind));
                check_field("waiter_res", want.waiter_res, rsp.waiter_res);
                check_field("woken_total", 8'(want.woken_total), 8'(rsp.woken_total));
                check_field("last", 8'(want.last), 8'(rsp.last));
            end
        end
        rsp_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
    end

endmodule
